[rtl/text_window_char_writer_top_defines.svh]
// assertion macros for the text window character writer
// used by text_window_char_writer_top, no other dependencies
`ifndef TEXT_WINDOW_CHAR_WRITER_TOP_DEFINES_SVH
`define TEXT_WINDOW_CHAR_WRITER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define TWC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/twc_pkg.sv]
// shared types and constants for the text window character writer
// no dependencies
package twc_pkg;
  localparam int unsigned RowsDef   = 25;
  localparam int unsigned ColsDef   = 80;
  localparam int unsigned TabDef    = 8;

  localparam logic [1:0] CmdPut   = 2'd0;
  localparam logic [1:0] CmdSet   = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7e;

  localparam logic [2:0] RegTop    = 3'd0;
  localparam logic [2:0] RegLeft   = 3'd1;
  localparam logic [2:0] RegBottom = 3'd2;
  localparam logic [2:0] RegRight  = 3'd3;
  localparam logic [2:0] RegScroll = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] code;
    logic [4:0] target_row;
    logic [6:0] target_col;
  } in_t;

  typedef struct packed {
    logic       status;
    logic [4:0] at_row;
    logic [6:0] at_col;
    logic [7:0] cell_code;
    logic [6:0] span_left;
    logic [6:0] span_right;
    logic       changed;
  } out_t;
endpackage

[rtl/text_window_char_writer_top.sv]
// text window character writer: cell memory, cursor, per-row dirty spans
// depends on twc_pkg and text_window_char_writer_top_defines.svh
//
//  channel | direction | handshake       | beat
//  in      | input     | in_valid/stall  | twc_pkg::in_t
//  out     | output    | out_valid/stall | twc_pkg::out_t
//  cfg     | input     | cfg_valid/ready | register index and data
//
// one item at a time; the cell memory has one port (one access a cycle,
// read data registered): set cursor and clear pass execute and done, a put
// writes its cell on execute and steps the cursor in done, a read waits in
// StRdW and StRdD; newline and tab blank one cell a cycle, a scroll copies
// each cell above the bottom row (a read, then a write), then blanks the bottom row.
// after reset a clearing pass writes spaces into all ROWS*COLS cells, one a
// cycle, before the first item is taken (config writes are taken meanwhile).
// the result sits in an output register; a stall on out holds it, the item
// waits in its last state until that register is free or being emptied, and
// the next item is taken the cycle after. the tab stop is the package constant
// twc_pkg::TabDef, a power of two.
`include "text_window_char_writer_top_defines.svh"
module text_window_char_writer_top #(
  parameter int unsigned ROWS     = twc_pkg::RowsDef,
  parameter int unsigned COLS     = twc_pkg::ColsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  twc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output twc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  localparam int unsigned Depth = ROWS * COLS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned TW    = $clog2(twc_pkg::TabDef);

  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StExec  = 4'd2;
  localparam logic [3:0] StRdW   = 4'd3;
  localparam logic [3:0] StRdD   = 4'd4;
  localparam logic [3:0] StBlank = 4'd5;
  localparam logic [3:0] StScrR  = 4'd6;
  localparam logic [3:0] StScrW  = 4'd7;
  localparam logic [3:0] StScrB  = 4'd8;
  localparam logic [3:0] StDone  = 4'd9;

  // configuration registers
  logic [4:0] top_q, bot_q;
  logic [6:0] left_q, right_q;
  logic       scroll_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0; left_q <= '0; bot_q <= 5'd24; right_q <= 7'd79; scroll_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        twc_pkg::RegTop:    top_q    <= cfg_data_i[4:0];
        twc_pkg::RegLeft:   left_q   <= cfg_data_i[6:0];
        twc_pkg::RegBottom: bot_q    <= cfg_data_i[4:0];
        twc_pkg::RegRight:  right_q  <= cfg_data_i[6:0];
        twc_pkg::RegScroll: scroll_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective window, saturated into the screen
  logic [7:0] wr0, wr1, wc0, wc1, rmax, cmax;
  always_comb begin
    wr0 = (8'(top_q) > 8'(ROWS - 1)) ? 8'(ROWS - 1) : 8'(top_q);
    wc0 = (8'(left_q) > 8'(COLS - 1)) ? 8'(COLS - 1) : 8'(left_q);
    wr1 = (8'(bot_q) > 8'(ROWS - 1)) ? 8'(ROWS - 1) : 8'(bot_q);
    if (wr1 < wr0) wr1 = wr0;
    wc1 = (8'(right_q) > 8'(COLS - 1)) ? 8'(COLS - 1) : 8'(right_q);
    if (wc1 < wc0) wc1 = wc0;
    rmax = wr1 - wr0;
    cmax = wc1 - wc0;
  end

  // cell memory, one port
  logic [7:0]    mem [Depth];
  logic          m_we, m_re;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wdata, m_rdata;
  always_ff @(posedge clk_i) begin
    if (m_we) mem[m_addr] <= m_wdata;
    if (m_re) m_rdata <= mem[m_addr];
  end

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
    logic [AW+7:0] a;
    a = (AW + 8)'(r) * (AW + 8)'(COLS) + (AW + 8)'(c);
    return a[AW-1:0];
  endfunction

  // dirty span marks, one pair of registers per screen row
  logic [6:0] lmark_q [ROWS];
  logic [6:0] rmark_q [ROWS];

  // control
  logic [3:0]    st_q, st_d;
  logic [AW-1:0] ptr_q, ptr_d;
  twc_pkg::in_t  it_q, it_d;
  logic [7:0]    crow_q, crow_d, ccol_q, ccol_d;
  logic [7:0]    r_q, r_d, c_q, c_d, stop_q, stop_d;
  logic          delta_q, delta_d;
  logic          status_q, status_d;
  logic          ov_q, ov_d;
  twc_pkg::out_t res_q, res_d;
  logic          ovalid_q, ovalid_d;

  // mark updates requested this cycle
  logic          mk_en, mk_all, clr_en;
  logic [7:0]    mk_r, mk_c;

  logic out_free;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = !(st_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

  logic [7:0] tr8, tc8, ccl, crl, tstop, sl_r;
  logic [TW-1:0] tmod;

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; it_d = it_q; crow_d = crow_q; ccol_d = ccol_q;
    r_d = r_q; c_d = c_q; stop_d = stop_q; delta_d = delta_q; status_d = status_q;
    ov_d = ov_q; res_d = res_q; ovalid_d = ovalid_q;
    m_we = 1'b0; m_re = 1'b0; m_addr = '0; m_wdata = twc_pkg::ChSpace;
    mk_en = 1'b0; mk_all = 1'b0; clr_en = 1'b0; mk_r = '0; mk_c = '0;
    tr8 = 8'(it_q.target_row); tc8 = 8'(it_q.target_col);
    ccl = (ccol_q > cmax) ? cmax : ccol_q;
    crl = (crow_q > rmax) ? rmax : crow_q;
    tmod = ccl[TW-1:0];
    tstop = ccl + 8'(twc_pkg::TabDef) - 8'(tmod);
    if (tstop > cmax) tstop = cmax;
    sl_r = wr0 + crow_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;

    unique case (st_q)
      StInit: begin
        m_we = 1'b1; m_addr = ptr_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == AW'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          it_d = in_data_i; st_d = StExec;
        end
      end
      StExec: begin
        crow_d = crl; ccol_d = ccl; status_d = 1'b0; ov_d = 1'b0;
        unique case (it_q.command)
          twc_pkg::CmdPut: begin
            if (it_q.code == twc_pkg::ChBs) begin
              if (ccl == 8'd0) status_d = 1'b1;
              else ccol_d = ccl - 8'd1;
              st_d = StDone;
            end else begin
              delta_d = 1'b1;
              if (it_q.code == twc_pkg::ChNl) begin
                c_d = ccl; stop_d = cmax; ov_d = 1'b1; st_d = StBlank;
              end else if (it_q.code == twc_pkg::ChTab) begin
                c_d = ccl; stop_d = tstop;
                st_d = (tstop > ccl) ? StBlank : StDone;
                if (tstop > ccl) ccol_d = tstop;
              end else begin
                if (it_q.code >= twc_pkg::ChSpace && it_q.code <= twc_pkg::ChTilde) begin
                  m_we = 1'b1; m_wdata = it_q.code;
                  m_addr = cell_addr(wr0 + crl, wc0 + ccl);
                end
                mk_en = 1'b1; mk_r = wr0 + crl; mk_c = wc0 + ccl;
                ov_d = 1'b1; st_d = StDone;
              end
            end
          end
          twc_pkg::CmdSet: begin
            crow_d = (tr8 > rmax) ? rmax : tr8;
            ccol_d = (tc8 > cmax) ? cmax : tc8;
            st_d = StDone;
          end
          twc_pkg::CmdRead: begin
            if (tr8 < 8'(ROWS) && tc8 < 8'(COLS)) begin
              m_re = 1'b1; m_addr = cell_addr(tr8, tc8); st_d = StRdW;
            end else begin
              status_d = 1'b1; st_d = StDone;
            end
          end
          default: begin
            if (tr8 >= 8'(ROWS)) status_d = 1'b1;
            st_d = StDone;
          end
        endcase
      end
      StRdW: st_d = StRdD;
      StRdD: st_d = StDone;
      StBlank: begin
        // one blank cell a cycle along the cursor row
        if (it_q.code == twc_pkg::ChNl ? (c_q <= stop_q) : (c_q < stop_q)) begin
          m_we = 1'b1; m_addr = cell_addr(wr0 + crow_q, wc0 + c_q);
          mk_en = 1'b1; mk_r = wr0 + crow_q; mk_c = wc0 + c_q;
          c_d = c_q + 8'd1;
        end else begin
          if (it_q.code == twc_pkg::ChNl) ccol_d = cmax;
          st_d = StDone;
        end
      end
      StScrR: begin
        // copy row r+1 into row r, read half
        m_re = 1'b1; m_addr = cell_addr(r_q + 8'd1, c_q); st_d = StScrW;
      end
      StScrW: begin
        m_we = 1'b1; m_wdata = m_rdata; m_addr = cell_addr(r_q, c_q);
        st_d = StScrR;
        if (c_q == wc1) begin
          c_d = wc0;
          if (r_q + 8'd1 == wr1) begin
            st_d = StScrB; r_d = wr1;
          end else r_d = r_q + 8'd1;
        end else c_d = c_q + 8'd1;
      end
      StScrB: begin
        m_we = 1'b1; m_addr = cell_addr(wr1, c_q);
        if (c_q == wc1) begin
          mk_all = 1'b1; st_d = StDone;
        end else c_d = c_q + 8'd1;
      end
      StDone: begin
        if (ov_q) begin
          // cursor advance after a put or newline
          ov_d = 1'b0;
          if (ccol_q < cmax) ccol_d = ccol_q + 8'd1;
          else if (crow_q < rmax) begin
            ccol_d = '0; crow_d = crow_q + 8'd1;
          end else if (scroll_q) begin
            ccol_d = '0; crow_d = rmax; r_d = wr0; c_d = wc0;
            st_d = (wr0 == wr1) ? StScrB : StScrR;
          end else status_d = 1'b1;
        end else if (out_free) begin
          res_d.status    = status_q;
          res_d.at_row    = crow_q[4:0];
          res_d.at_col    = ccol_q[6:0];
          res_d.cell_code = '0;
          res_d.span_left = 7'(COLS);
          res_d.span_right = '0;
          res_d.changed   = delta_q;
          if (it_q.command == twc_pkg::CmdPut || it_q.command == twc_pkg::CmdSet) begin
            res_d.span_left  = lmark_q[sl_r[RW-1:0]];
            res_d.span_right = rmark_q[sl_r[RW-1:0]];
          end else if (!status_q) begin
            res_d.span_left  = lmark_q[tr8[RW-1:0]];
            res_d.span_right = rmark_q[tr8[RW-1:0]];
            if (it_q.command == twc_pkg::CmdRead) res_d.cell_code = m_rdata;
            else clr_en = 1'b1;
          end
          ovalid_d = 1'b1;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; ptr_q <= '0; ovalid_q <= 1'b0; delta_q <= 1'b0;
      crow_q <= '0; ccol_q <= '0; ov_q <= 1'b0; status_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        lmark_q[i] <= 7'(COLS); rmark_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; ovalid_q <= ovalid_d; delta_q <= delta_d;
      crow_q <= crow_d; ccol_q <= ccol_d; ov_q <= ov_d; status_q <= status_d;
      for (int i = 0; i < ROWS; i++) begin
        if (mk_en && mk_r == 8'(i)) begin
          if (mk_c[6:0] < lmark_q[i]) lmark_q[i] <= mk_c[6:0];
          if (mk_c[6:0] > rmark_q[i]) rmark_q[i] <= mk_c[6:0];
        end
        if (mk_all && 8'(i) >= wr0 && 8'(i) <= wr1) begin
          if (wc0[6:0] < lmark_q[i]) lmark_q[i] <= wc0[6:0];
          if (wc1[6:0] > rmark_q[i]) rmark_q[i] <= wc1[6:0];
        end
        if (clr_en && tr8 == 8'(i)) begin
          lmark_q[i] <= 7'(COLS); rmark_q[i] <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    it_d_reg: begin
      it_q <= it_d; r_q <= r_d; c_q <= c_d; stop_q <= stop_d; res_q <= res_d;
    end
  end

  `TWC_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, st_q != StIdle, in_stall_o)
  `TWC_ASSERT_NEXT(a_take_exec, clk_i, rst_ni, in_valid_i && !in_stall_o, st_q == StExec)
  `TWC_ASSERT_IMP(a_one_mark, clk_i, rst_ni, clr_en, !mk_en && !mk_all)
  `TWC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o))
endmodule

[verif/tb_top.sv]
// self-checking testbench for text_window_char_writer_top
// depends on twc_pkg and the rtl top level; holds its own cursor, cell and span predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR    = twc_pkg::RowsDef;
  localparam int NC    = twc_pkg::ColsDef;
  localparam int TSTEP = twc_pkg::TabDef;

  // clock, reset and block ports
  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  twc_pkg::in_t  in_beat = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  twc_pkg::out_t out_beat;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = twc_pkg::RegTop;
  logic [31:0]   cfg_data = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_window_char_writer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // stimulus and expected results
  twc_pkg::in_t  pending_beats[$];
  twc_pkg::out_t expected_results[$];
  int   snd_idle_pct = 0;
  int   rcv_stall_pct = 0;
  int   mismatches = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   error_results = 0;
  int   scroll_cnt = 0;
  int   settings_cnt = 0;

  // ---------------------------------------------------------------------------
  // screen predictor: register copies, cell store, dirty spans and cursor
  // ---------------------------------------------------------------------------
  logic [4:0] top_q = 5'd0, bottom_q = 5'd24;
  logic [6:0] left_q = 7'd0, right_q = 7'd79;
  logic       scroll_q = 1'b1;

  logic [7:0] screen_cells [NR*NC];
  int         span_lo [NR];
  int         span_hi [NR];
  int         cur_r = 0, cur_c = 0;
  logic       dirty = 1'b0;
  int         w_r0, w_r1, w_c0, w_c1, r_lim, c_lim;

  initial begin
    for (int i = 0; i < NR*NC; i++) screen_cells[i] = twc_pkg::ChSpace;
    for (int r = 0; r < NR; r++) begin
      span_lo[r] = NC;
      span_hi[r] = 0;
    end
  end

  // saturate the registers into a legal window
  function automatic void fit_window();
    w_r0 = (top_q > NR-1) ? NR-1 : top_q;
    w_c0 = (left_q > NC-1) ? NC-1 : left_q;
    w_r1 = (bottom_q > NR-1) ? NR-1 : bottom_q;
    if (w_r1 < w_r0) w_r1 = w_r0;
    w_c1 = (right_q > NC-1) ? NC-1 : right_q;
    if (w_c1 < w_c0) w_c1 = w_c0;
    r_lim = w_r1 - w_r0;
    c_lim = w_c1 - w_c0;
  endfunction

  function automatic void mark_col(int r, int c);
    if (c < span_lo[r]) span_lo[r] = c;
    if (c > span_hi[r]) span_hi[r] = c;
  endfunction

  // window-relative write, the column is marked even when nothing is stored
  function automatic void write_cell(int row, int col, logic [7:0] ch, bit keep);
    int r, c;
    r = w_r0 + row;
    c = w_c0 + col;
    if (keep) screen_cells[r*NC + c] = ch;
    mark_col(r, c);
  endfunction

  function automatic void scroll_window();
    for (int r = w_r0; r < w_r1; r++)
      for (int c = w_c0; c <= w_c1; c++)
        screen_cells[r*NC + c] = screen_cells[(r+1)*NC + c];
    for (int c = w_c0; c <= w_c1; c++) screen_cells[w_r1*NC + c] = twc_pkg::ChSpace;
    for (int r = w_r0; r <= w_r1; r++) begin
      mark_col(r, w_c0);
      mark_col(r, w_c1);
    end
    scroll_cnt++;
  endfunction

  // step the cursor on, returns 1 on overflow with scrolling off
  function automatic bit step_cursor();
    if (cur_c < c_lim) begin
      cur_c++;
    end else if (cur_r < r_lim) begin
      cur_c = 0;
      cur_r++;
    end else if (scroll_q) begin
      scroll_window();
      cur_c = 0;
      cur_r = r_lim;
    end else begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit apply_put(logic [7:0] ch);
    int stop;
    if (ch == twc_pkg::ChBs) begin
      if (cur_c == 0) return 1'b1;
      cur_c--;
      return 1'b0;
    end
    dirty = 1'b1;
    if (ch == twc_pkg::ChNl) begin
      for (int c = cur_c; c <= c_lim; c++) write_cell(cur_r, c, twc_pkg::ChSpace, 1'b1);
      cur_c = c_lim;
      return step_cursor();
    end
    if (ch == twc_pkg::ChTab) begin
      stop = cur_c + TSTEP - (cur_c % TSTEP);
      if (stop > c_lim) stop = c_lim;
      for (int c = cur_c; c < stop; c++) write_cell(cur_r, c, twc_pkg::ChSpace, 1'b1);
      if (stop > cur_c) cur_c = stop;
      return 1'b0;
    end
    write_cell(cur_r, cur_c, ch, ch >= twc_pkg::ChSpace && ch <= twc_pkg::ChTilde);
    return step_cursor();
  endfunction

  function automatic twc_pkg::out_t predict_beat(twc_pkg::in_t b);
    twc_pkg::out_t o;
    int   tr, tc;
    tr = b.target_row;
    tc = b.target_col;
    o = '0;
    o.span_left = 7'(NC);
    fit_window();
    if (cur_r > r_lim) cur_r = r_lim;
    if (cur_c > c_lim) cur_c = c_lim;
    case (b.command)
      twc_pkg::CmdPut, twc_pkg::CmdSet: begin
        if (b.command == twc_pkg::CmdPut) begin
          o.status = apply_put(b.code);
        end else begin
          cur_r = (tr > r_lim) ? r_lim : tr;
          cur_c = (tc > c_lim) ? c_lim : tc;
        end
        o.span_left  = 7'(span_lo[w_r0 + cur_r]);
        o.span_right = 7'(span_hi[w_r0 + cur_r]);
      end
      twc_pkg::CmdRead: begin
        if (tr < NR && tc < NC) begin
          o.cell_code  = screen_cells[tr*NC + tc];
          o.span_left  = 7'(span_lo[tr]);
          o.span_right = 7'(span_hi[tr]);
        end else begin
          o.status = 1'b1;
        end
      end
      default: begin
        if (tr < NR) begin
          // report the span held before the clear
          o.span_left  = 7'(span_lo[tr]);
          o.span_right = 7'(span_hi[tr]);
          span_lo[tr]  = NC;
          span_hi[tr]  = 0;
        end else begin
          o.status = 1'b1;
        end
      end
    endcase
    o.at_row  = 5'(cur_r);
    o.at_col  = 7'(cur_c);
    o.changed = dirty;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: next beat only once the current one has gone
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_beat(in_beat));
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: random stall, compare each result beat with the oldest one
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    twc_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat, status", out_beat.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (want.status) error_results++;
          if (out_beat.status !== want.status)
            report_mismatch("status", out_beat.status, want.status);
          if (out_beat.at_row !== want.at_row)
            report_mismatch("at_row", out_beat.at_row, want.at_row);
          if (out_beat.at_col !== want.at_col)
            report_mismatch("at_col", out_beat.at_col, want.at_col);
          if (out_beat.cell_code !== want.cell_code)
            report_mismatch("cell_code", out_beat.cell_code, want.cell_code);
          if (out_beat.span_left !== want.span_left)
            report_mismatch("span_left", out_beat.span_left, want.span_left);
          if (out_beat.span_right !== want.span_right)
            report_mismatch("span_right", out_beat.span_right, want.span_right);
          if (out_beat.changed !== want.changed)
            report_mismatch("changed", out_beat.changed, want.changed);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic twc_pkg::in_t make_beat(logic [1:0] cmd, logic [7:0] ch, int tr, int tc);
    twc_pkg::in_t b;
    b.command    = cmd;
    b.code       = ch;
    b.target_row = 5'(tr);
    b.target_col = 7'(tc);
    return b;
  endfunction

  // mostly printable puts, with control codes, cursor moves, reads and clears
  function automatic twc_pkg::in_t random_beat();
    int         k;
    logic [1:0] cmd;
    logic [7:0] ch;
    k = $urandom_range(99);
    cmd = (k < 55) ? twc_pkg::CmdPut : (k < 70) ? twc_pkg::CmdSet :
          (k < 85) ? twc_pkg::CmdRead : twc_pkg::CmdClear;
    k = $urandom_range(99);
    if (k < 60)      ch = 8'($urandom_range(twc_pkg::ChTilde, twc_pkg::ChSpace));
    else if (k < 70) ch = twc_pkg::ChBs;
    else if (k < 78) ch = twc_pkg::ChTab;
    else if (k < 86) ch = twc_pkg::ChNl;
    else             ch = 8'($urandom_range(255));
    return make_beat(cmd, ch,
                     ($urandom_range(99) < 85) ? $urandom_range(NR-1) : $urandom_range(31, NR),
                     ($urandom_range(99) < 85) ? $urandom_range(NC-1) : $urandom_range(127, NC));
  endfunction

  // caller stands at a clock edge; valid stays high across back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      twc_pkg::RegTop:    top_q    = val[4:0];
      twc_pkg::RegLeft:   left_q   = val[6:0];
      twc_pkg::RegBottom: bottom_q = val[4:0];
      twc_pkg::RegRight:  right_q  = val[6:0];
      twc_pkg::RegScroll: scroll_q = val[0];
      default: ;
    endcase
  endtask

  // wait until every beat has gone in and every result has come out
  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_setting(int t, int l, int b, int r, int s, int n);
    write_reg(twc_pkg::RegTop, t);
    write_reg(twc_pkg::RegLeft, l);
    write_reg(twc_pkg::RegBottom, b);
    write_reg(twc_pkg::RegRight, r);
    write_reg(twc_pkg::RegScroll, s);
    cfg_valid <= 1'b0;
    settings_cnt++;
    repeat (n) pending_beats.push_back(random_beat());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats on the reset window: code extremes, control codes, errors
    snd_idle_pct  = 14;
    rcv_stall_pct = 66;
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChBs, 0, 0)); // bs at column 0
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChSpace, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChTilde, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, 8'h00, 0, 0));      // non-printable
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, 8'hff, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChBs, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChTab, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChNl, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdSet, 8'h00, 31, 127));   // clamped
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChTab, 0, 0)); // last column
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, 8'h41, 0, 0));      // overflow, scroll
    pending_beats.push_back(make_beat(twc_pkg::CmdSet, 8'h00, NR-1, NC-1));
    pending_beats.push_back(make_beat(twc_pkg::CmdPut, twc_pkg::ChNl, 0, 0)); // bottom, scroll
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'h00, 0, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'h00, NR-2, 1));
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'h00, NR-1, NC-1));
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'h00, NR, 0));    // off screen
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'h00, 0, NC));
    pending_beats.push_back(make_beat(twc_pkg::CmdRead, 8'hff, 31, 127));
    pending_beats.push_back(make_beat(twc_pkg::CmdClear, 8'h00, NR-1, 0));
    pending_beats.push_back(make_beat(twc_pkg::CmdClear, 8'h00, NR-1, 0)); // span now empty
    pending_beats.push_back(make_beat(twc_pkg::CmdClear, 8'h00, 31, 127));
    pending_beats.push_back(make_beat(twc_pkg::CmdSet, 8'h00, 0, 0));
    drain();

    // window settings: full, corners, saturated, inverted, single row
    run_setting(0, 0, 24, 79, 0, 150);       // full screen, overflow is an error
    run_setting(20, 70, 24, 79, 1, 350);
    snd_idle_pct  = 66;
    rcv_stall_pct = 14;
    run_setting(3, 10, 5, 25, 0, 300);
    run_setting(31, 127, 0, 0, 1, 250);      // saturates to one cell
    run_setting(10, 40, 4, 20, 1, 250);      // bottom and right raised to top and left
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_setting(0, 0, 24, 79, 1, 150);
    run_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 300);
    run_setting(12, 0, 12, 79, 1, 250);

    $display("covered %0d beats over %0d window settings plus the reset window",
             beats_sent, settings_cnt);
    $display("%0d results checked, %0d error results, %0d scrolls",
             results_seen, error_results, scroll_cnt);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #200_000_000;
    $display("timeout waiting for result beats");
    $display("tb_top failed");
    $finish;
  end

endmodule
